/* rtl/srle_pkg.sv */
// shared types and constants for the sgi rle row decoder
package srle_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned COLUMN_W = 16;

    localparam logic [COLUMN_W-1:0] ROW_WIDTH_RESET = 16'd256;
    localparam int unsigned          LITERAL_BIT    = 7;

    typedef enum logic [1:0] {
        PH_CTRL = 2'd0,
        PH_LIT  = 2'd1,
        PH_REP  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   value;
        logic [COUNT_W-1:0]  length;
        logic [COLUMN_W-1:0] start_column;
        logic                row_done;
        logic                overflow;
    } run_t;

endpackage

/* rtl/sgi_rle_row_decoder.sv */
// Decodes one scanline of SGI RGB run-length data into run descriptors, one
// compressed byte per transfer on the s_ channel. A control byte with a nonzero
// count produces no result; a literal byte, a repeat value byte or a zero-count
// control byte (end of row) produces one run on the m_ channel. The block takes
// one byte every cycle unless a byte with a result waits on m_ready. A byte is
// decoded combinationally between the input register and the result register,
// and stalls on m_ready only hold bytes that produce a result. row_width (reset
// 256) is written through cfg_wr_en and cfg_wr_data and takes effect for the
// next decoded byte.
module sgi_rle_row_decoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [srle_pkg::COLUMN_W-1:0] cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [srle_pkg::BYTE_W-1:0]   s_in_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [srle_pkg::BYTE_W-1:0]   m_run_value,
    output logic [srle_pkg::COUNT_W-1:0]  m_run_length,
    output logic [srle_pkg::COLUMN_W-1:0] m_start_column,
    output logic                          m_row_done,
    output logic                          m_overflow
);

    logic [srle_pkg::COLUMN_W-1:0] row_width_reg;
    logic                          consume;
    logic                          byte_valid;
    logic [srle_pkg::BYTE_W-1:0]   byte_data;
    logic                          out_free;
    logic                          run_valid;
    srle_pkg::run_t                run;
    srle_pkg::run_t                m_run;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg <= srle_pkg::ROW_WIDTH_RESET;
        end else if (cfg_wr_en) begin
            row_width_reg <= cfg_wr_data;
        end
    end

    srle_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .consume    (consume),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    srle_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .row_width  (row_width_reg),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .out_free   (out_free),
        .consume    (consume),
        .run_valid  (run_valid),
        .run        (run)
    );

    srle_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .run_valid (run_valid),
        .run       (run),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_run     (m_run)
    );

    assign m_run_value    = m_run.value;
    assign m_run_length   = m_run.length;
    assign m_start_column = m_run.start_column;
    assign m_row_done     = m_run.row_done;
    assign m_overflow     = m_run.overflow;

endmodule

/* rtl/srle_in_reg.sv */
// input register stage holding one compressed byte
module srle_in_reg (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [srle_pkg::BYTE_W-1:0] s_in_byte,
    input  logic                      consume,
    output logic                      byte_valid,
    output logic [srle_pkg::BYTE_W-1:0] byte_data
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [srle_pkg::BYTE_W-1:0] byte_reg;
    logic                        load;

    // the held byte leaves in the same cycle a new one can enter
    assign s_ready = !valid_reg || consume;
    assign load    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (consume) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= s_in_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

/* rtl/srle_decode.sv */
// decode state (phase, remaining, column) and per-byte run logic
module srle_decode (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [srle_pkg::COLUMN_W-1:0] row_width,
    input  logic                          byte_valid,
    input  logic [srle_pkg::BYTE_W-1:0]   byte_data,
    input  logic                          out_free,
    output logic                          consume,
    output logic                          run_valid,
    output srle_pkg::run_t                run
);

    srle_pkg::phase_t               phase_reg;
    srle_pkg::phase_t               phase_next;
    logic [srle_pkg::COUNT_W-1:0]   remaining_reg;
    logic [srle_pkg::COUNT_W-1:0]   remaining_next;
    logic [srle_pkg::COLUMN_W-1:0]  column_reg;
    logic [srle_pkg::COLUMN_W-1:0]  column_next;

    logic [srle_pkg::COUNT_W-1:0]   count;
    logic [srle_pkg::COUNT_W-1:0]   run_len;
    logic [srle_pkg::COLUMN_W:0]    run_end;
    logic                           run_ovf;
    logic                           produces;

    assign count = byte_data[srle_pkg::COUNT_W-1:0];

    always_comb begin
        run_len = remaining_reg;
        if (phase_reg == srle_pkg::PH_LIT) begin
            run_len = srle_pkg::COUNT_W'(1);
        end
    end

    assign run_end = {1'b0, column_reg} + {{(srle_pkg::COLUMN_W + 1 - srle_pkg::COUNT_W){1'b0}},
                                           run_len};
    assign run_ovf = run_end > {1'b0, row_width};

    always_comb begin
        produces = 1'b1;
        if (phase_reg != srle_pkg::PH_LIT && phase_reg != srle_pkg::PH_REP) begin
            produces = (count == '0);
        end
    end

    // a control byte with a nonzero count never needs the output side
    assign consume   = byte_valid && (!produces || out_free);
    assign run_valid = consume && produces;

    always_comb begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        column_next    = column_reg;
        run.value        = byte_data;
        run.length       = run_len;
        run.start_column = column_reg;
        run.row_done     = 1'b0;
        run.overflow     = run_ovf;
        case (phase_reg)
            srle_pkg::PH_LIT: begin
                column_next    = run_ovf ? row_width : run_end[srle_pkg::COLUMN_W-1:0];
                remaining_next = remaining_reg - srle_pkg::COUNT_W'(1);
                if (remaining_next == '0) begin
                    phase_next = srle_pkg::PH_CTRL;
                end
            end
            srle_pkg::PH_REP: begin
                column_next    = run_ovf ? row_width : run_end[srle_pkg::COLUMN_W-1:0];
                remaining_next = '0;
                phase_next     = srle_pkg::PH_CTRL;
            end
            default: begin
                // control byte; unused phase code lands here too
                run.value    = '0;
                run.length   = '0;
                run.row_done = 1'b1;
                run.overflow = 1'b0;
                if (count == '0) begin
                    column_next    = '0;
                    remaining_next = '0;
                    phase_next     = srle_pkg::PH_CTRL;
                end else begin
                    remaining_next = count;
                    phase_next     = byte_data[srle_pkg::LITERAL_BIT] ? srle_pkg::PH_LIT
                                                                      : srle_pkg::PH_REP;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= srle_pkg::PH_CTRL;
            remaining_reg <= '0;
            column_reg    <= '0;
        end else if (consume) begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            column_reg    <= column_next;
        end
    end

endmodule

/* rtl/srle_out_reg.sv */
// result register for one run descriptor
module srle_out_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           run_valid,
    input  srle_pkg::run_t run,
    output logic           out_free,
    output logic           m_valid,
    input  logic           m_ready,
    output srle_pkg::run_t m_run
);

    logic           valid_reg;
    logic           valid_next;
    srle_pkg::run_t run_reg;

    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (run_valid) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (run_valid) begin
            run_reg <= run;
        end
    end

    assign m_valid = valid_reg;
    assign m_run   = run_reg;

endmodule

/* verif/testbench.sv */
// self-checking testbench for the sgi rle row decoder
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_BYTES = 1650;
    localparam int PIPE_SETTLE = 4;
    localparam int STUCK_LIMIT = 2000;

    localparam logic ROW_BYTE  = 1'b0;
    localparam logic ROW_WIDTH = 1'b1;

    localparam logic [srle_pkg::BYTE_W-1:0] END_OF_ROW     = 8'h00;
    localparam logic [srle_pkg::BYTE_W-1:0] END_OF_ROW_LIT = 8'h80;

    typedef struct packed {
        logic                          kind;
        logic                          typed;
        logic [srle_pkg::COLUMN_W-1:0] data;
        srle_pkg::run_t                want;
    } script_row_t;

    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          cfg_wr_en   = 1'b0;
    logic [srle_pkg::COLUMN_W-1:0] cfg_wr_data = '0;
    logic                          s_valid     = 1'b0;
    logic                          s_ready;
    logic [srle_pkg::BYTE_W-1:0]   s_in_byte   = '0;
    logic                          m_valid;
    logic                          m_ready     = 1'b0;
    logic [srle_pkg::BYTE_W-1:0]   m_run_value;
    logic [srle_pkg::COUNT_W-1:0]  m_run_length;
    logic [srle_pkg::COLUMN_W-1:0] m_start_column;
    logic                          m_row_done;
    logic                          m_overflow;

    sgi_rle_row_decoder dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_run_value    (m_run_value),
        .m_run_length   (m_run_length),
        .m_start_column (m_start_column),
        .m_row_done     (m_row_done),
        .m_overflow     (m_overflow)
    );

    always #10 aclk = ~aclk;

    // decoder state as the block should hold it
    srle_pkg::phase_t              dec_phase  = srle_pkg::PH_CTRL;
    logic [srle_pkg::COUNT_W-1:0]  run_left   = '0;
    logic [srle_pkg::COLUMN_W-1:0] cur_column = '0;
    logic [srle_pkg::COLUMN_W-1:0] width_reg  = srle_pkg::ROW_WIDTH_RESET;

    srle_pkg::run_t expected_runs[$];
    srle_pkg::run_t next_run;
    int   errors     = 0;
    int   byte_count = 0;
    int   stuck      = 0;
    int   stall_left = 0;
    bit   quiet_in   = 1'b0;
    bit   quiet_out  = 1'b0;

    task automatic place_run(input logic [srle_pkg::BYTE_W-1:0] value,
                             input logic [srle_pkg::COUNT_W-1:0] len,
                             output srle_pkg::run_t run);
        logic [srle_pkg::COLUMN_W:0] run_end;
        run_end          = {1'b0, cur_column} + len;
        run.value        = value;
        run.length       = len;
        run.start_column = cur_column;
        run.row_done     = 1'b0;
        run.overflow     = run_end > {1'b0, width_reg};
        cur_column       = run.overflow ? width_reg : run_end[srle_pkg::COLUMN_W-1:0];
    endtask

    task automatic decode_byte(input logic [srle_pkg::BYTE_W-1:0] b, output logic has_run,
                               output srle_pkg::run_t run);
        run     = '0;
        has_run = 1'b1;
        case (dec_phase)
            srle_pkg::PH_LIT: begin
                place_run(b, 7'd1, run);
                run_left = run_left - 1'b1;
                if (run_left == 0) dec_phase = srle_pkg::PH_CTRL;
            end
            srle_pkg::PH_REP: begin
                place_run(b, run_left, run);
                run_left  = '0;
                dec_phase = srle_pkg::PH_CTRL;
            end
            default: begin
                if (b[srle_pkg::COUNT_W-1:0] == 0) begin
                    // end of row: report the column reached, then restart
                    run.start_column = cur_column;
                    run.row_done     = 1'b1;
                    cur_column       = '0;
                    run_left         = '0;
                    dec_phase        = srle_pkg::PH_CTRL;
                end else begin
                    has_run   = 1'b0;
                    run_left  = b[srle_pkg::COUNT_W-1:0];
                    dec_phase = b[srle_pkg::LITERAL_BIT] ? srle_pkg::PH_LIT
                                                         : srle_pkg::PH_REP;
                end
            end
        endcase
    endtask

    function automatic int pause_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    endfunction

    function automatic script_row_t byte_row(input logic [srle_pkg::BYTE_W-1:0] b);
        script_row_t r;
        r      = '0;
        r.kind = ROW_BYTE;
        r.data = srle_pkg::COLUMN_W'(b);
        return r;
    endfunction

    function automatic script_row_t typed_row(input logic [srle_pkg::BYTE_W-1:0] b,
                                              input logic [srle_pkg::BYTE_W-1:0] value,
                                              input logic [srle_pkg::COUNT_W-1:0] len,
                                              input logic [srle_pkg::COLUMN_W-1:0] col,
                                              input logic done, input logic ovf);
        script_row_t r;
        r                   = byte_row(b);
        r.typed             = 1'b1;
        r.want.value        = value;
        r.want.length       = len;
        r.want.start_column = col;
        r.want.row_done     = done;
        r.want.overflow     = ovf;
        return r;
    endfunction

    function automatic script_row_t width_row(input logic [srle_pkg::COLUMN_W-1:0] w);
        script_row_t r;
        r      = '0;
        r.kind = ROW_WIDTH;
        r.data = w;
        return r;
    endfunction

    // entered and left at a falling edge
    task automatic send_byte(input logic [srle_pkg::BYTE_W-1:0] b, input logic typed,
                             input srle_pkg::run_t want);
        int             gap;
        logic           has_run;
        srle_pkg::run_t run;
        gap = (quiet_in || $urandom_range(0, 2) != 0) ? 0 : pause_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        decode_byte(b, has_run, run);
        if (has_run) expected_runs.push_back(typed ? want : run);
        byte_count++;
        @(negedge aclk);
    endtask

    task automatic send_data(input logic [srle_pkg::BYTE_W-1:0] b);
        send_byte(b, 1'b0, '0);
    endtask

    // drain the block, then write row_width
    task automatic write_width(input logic [srle_pkg::COLUMN_W-1:0] w);
        s_valid <= 1'b0;
        while (expected_runs.size() != 0) @(negedge aclk);
        repeat (PIPE_SETTLE) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        width_reg = w;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    initial begin
        forever @(negedge aclk) begin
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (!quiet_out && $urandom_range(0, 4) == 0) stall_left = pause_len();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_runs.size() == 0) begin
                $display("%0t: unexpected run, value %0d length %0d column %0d done %0b ovf %0b",
                         $time, m_run_value, m_run_length, m_start_column, m_row_done,
                         m_overflow);
                errors++;
            end else begin
                next_run = expected_runs.pop_front();
                check_field("run_value", next_run.value, m_run_value);
                check_field("run_length", next_run.length, m_run_length);
                check_field("start_column", next_run.start_column, m_start_column);
                check_field("row_done", next_run.row_done, m_row_done);
                check_field("overflow", next_run.overflow, m_overflow);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) stuck = 0;
            else stuck++;
            if (stuck >= STUCK_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        script_row_t script[$];
        int          n;
        int          packets;
        int          target;
        logic [srle_pkg::COLUMN_W-1:0] w;

        // reset width 256: row ends, literal and repeat runs, overflow with saturation
        script.push_back(typed_row(8'h00, 8'h00, 7'd0, 16'd0, 1'b1, 1'b0));
        script.push_back(byte_row(8'h83));
        script.push_back(typed_row(8'h00, 8'h00, 7'd1, 16'd0, 1'b0, 1'b0));
        script.push_back(typed_row(8'hFF, 8'hFF, 7'd1, 16'd1, 1'b0, 1'b0));
        script.push_back(byte_row(8'h5A));
        script.push_back(byte_row(8'h7F));
        script.push_back(typed_row(8'hA5, 8'hA5, 7'd127, 16'd3, 1'b0, 1'b0));
        script.push_back(byte_row(8'h7F));
        script.push_back(typed_row(8'h3C, 8'h3C, 7'd127, 16'd130, 1'b0, 1'b1));
        script.push_back(byte_row(8'h01));
        script.push_back(typed_row(8'h11, 8'h11, 7'd1, 16'd256, 1'b0, 1'b1));
        script.push_back(typed_row(8'h80, 8'h00, 7'd0, 16'd256, 1'b1, 1'b0));
        // narrowest legal row
        script.push_back(width_row(16'd1));
        script.push_back(byte_row(8'h82));
        script.push_back(typed_row(8'h10, 8'h10, 7'd1, 16'd0, 1'b0, 1'b0));
        script.push_back(typed_row(8'h20, 8'h20, 7'd1, 16'd1, 1'b0, 1'b1));
        script.push_back(typed_row(8'h00, 8'h00, 7'd0, 16'd1, 1'b1, 1'b0));
        // zero width: the repeat run overflows, column pinned at 0
        script.push_back(width_row(16'd0));
        script.push_back(byte_row(8'h05));
        script.push_back(typed_row(8'h33, 8'h33, 7'd5, 16'd0, 1'b0, 1'b1));
        script.push_back(typed_row(8'h80, 8'h00, 7'd0, 16'd0, 1'b1, 1'b0));
        // widest row, then shrink below the column mid-row
        script.push_back(width_row(16'hFFFF));
        script.push_back(byte_row(8'h7F));
        script.push_back(typed_row(8'h44, 8'h44, 7'd127, 16'd0, 1'b0, 1'b0));
        script.push_back(width_row(16'd100));
        script.push_back(byte_row(8'h81));
        script.push_back(byte_row(8'h55));
        script.push_back(byte_row(8'h00));

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (script[i]) begin
            if (script[i].kind == ROW_WIDTH) write_width(script[i].data);
            else send_byte(script[i].data[srle_pkg::BYTE_W-1:0], script[i].typed,
                           script[i].want);
        end

        while (byte_count < TOTAL_BYTES) begin
            case ($urandom_range(0, 9))
                0:       w = 16'd1;
                1:       w = 16'hFFFF;
                2:       w = 16'($urandom_range(1, 16'hFFFF));
                default: w = 16'($urandom_range(1, 400));
            endcase
            write_width(w);
            quiet_in  = ($urandom_range(0, 3) == 0);
            quiet_out = ($urandom_range(0, 3) == 0);
            target    = byte_count + $urandom_range(60, 300);
            while (byte_count < target) begin
                if ($urandom_range(0, 7) == 0) begin
                    // noise: arbitrary bytes wherever the decoder happens to be
                    repeat ($urandom_range(1, 6)) send_data(8'($urandom));
                end else begin
                    packets = $urandom_range(1, 6);
                    repeat (packets) begin
                        if ($urandom_range(0, 1) == 1) begin
                            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 127)
                                                            : $urandom_range(1, 8);
                            send_data({1'b1, 7'(n)});
                            repeat (n) send_data(8'($urandom));
                        end else begin
                            send_data({1'b0, 7'($urandom_range(1, 127))});
                            send_data(8'($urandom));
                        end
                    end
                    send_data($urandom_range(0, 1) ? END_OF_ROW_LIT : END_OF_ROW);
                end
            end
        end

        s_valid <= 1'b0;
        while (expected_runs.size() != 0) @(negedge aclk);
        repeat (2 * PIPE_SETTLE) @(negedge aclk);
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
